[src/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that ante implies cons at the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that ante implies cons at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[src/spims_pkg.sv]
// Package with bus operation codes, register indexes and rate table of the SPI master.
package spims_pkg;

	// Bus access carried by one beat.
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [3:0] CFG_SPI_ENABLE     = 4'd0;
	localparam logic [3:0] CFG_IRQ_ENABLE     = 4'd1;
	localparam logic [3:0] CFG_LSB_FIRST      = 4'd2;
	localparam logic [3:0] CFG_CLOCK_POLARITY = 4'd3;
	localparam logic [3:0] CFG_CLOCK_PHASE    = 4'd4;
	localparam logic [3:0] CFG_RATE_SELECT    = 4'd5;
	localparam logic [3:0] CFG_DOUBLE_SPEED   = 4'd6;
	localparam logic [3:0] CFG_MASTER_SELECT  = 4'd7;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int PRESCALE_W  = 6;

	// Half bit period in ticks for each rate code.
	typedef logic [PRESCALE_W:0] half_t;
	localparam half_t HALF_PERIOD [4] = '{7'd2, 7'd8, 7'd32, 7'd64};

	// Status byte bit positions.
	localparam int STATUS_DONE_BIT      = 7;
	localparam int STATUS_COLLISION_BIT = 6;

endpackage

[src/spi_master_shift_engine.sv]
// SPI master shift engine, modes 0 to 3, with bus access per tick.
// The result beat of an accepted beat is registered in the output register.
// Throughput: one beat per cycle while not stalled; a new result enters as the old one leaves.
// The serial engine, flags and bus access are computed in one pass from registered state.
// Reset (arst_n low) clears configuration, engine state, flags and the output valid at once.
module spi_master_shift_engine #(
	parameter int DATA_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           op,
	input  logic [7:0]                           write_byte,
	input  logic                                 miso_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           read_value,
	output logic                                 sck_out,
	output logic                                 mosi_out,
	output logic                                 select_n,
	output logic                                 irq,
	output logic                                 busy_res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [spims_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [spims_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import spims_pkg::*;

`include "assert_macros.svh"

	localparam int EDGE_W = $clog2(2 * DATA_BITS + 1);
	localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(2 * DATA_BITS);

	// Shift one bit into the word from the side opposite the output end.
	function automatic logic [DATA_BITS-1:0] shift_word(
		input logic [DATA_BITS-1:0] word,
		input logic                 bit_in,
		input logic                 lsb
	);
		logic [DATA_BITS-1:0] res;
		if (lsb) begin
			res = {bit_in, word[DATA_BITS-1:1]};
		end else begin
			res = {word[DATA_BITS-2:0], bit_in};
		end
		return res;
	endfunction

	// Configuration registers
	logic       spi_enable_q, irq_enable_q, lsb_first_q, clock_polarity_q;
	logic       clock_phase_q, double_speed_q, master_select_q;
	logic [1:0] rate_select_q;

	// Engine state
	logic [DATA_BITS-1:0]  shift_q;
	logic [EDGE_W-1:0]     edge_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic                  active_q, clock_level_q, done_q, collision_q, latch_q;
	logic [7:0]            rx_buf_q;

	// Next state
	logic [DATA_BITS-1:0]  shift_d;
	logic [EDGE_W-1:0]     edge_d;
	logic [PRESCALE_W-1:0] prescale_d;
	logic                  active_d, clock_level_d, done_d, collision_d, latch_d;
	logic [7:0]            rx_buf_d;
	logic [7:0]            read_d;

	logic [PRESCALE_W:0]   half;
	logic [PRESCALE_W:0]   pre_inc;
	logic [DATA_BITS+7:0]  wb_ext;
	logic [DATA_BITS+7:0]  sh_ext;
	logic                  accept;
	op_t                   op_c;

	logic                  out_valid_q;
	logic [7:0]            read_value_q;
	logic                  sck_q, mosi_q, select_n_q, irq_q, busy_q;

	assign op_c     = op_t'(op);
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign half    = double_speed_q ? (HALF_PERIOD[rate_select_q] >> 1)
	                                : HALF_PERIOD[rate_select_q];
	assign pre_inc = {1'b0, prescale_q} + 7'd1;
	assign wb_ext  = {{DATA_BITS{1'b0}}, write_byte};

	// Advance the serial engine one tick, then apply the bus access
	always_comb begin
		shift_d       = shift_q;
		edge_d        = edge_q;
		prescale_d    = prescale_q;
		active_d      = active_q;
		clock_level_d = clock_level_q;
		done_d        = done_q;
		collision_d   = collision_q;
		latch_d       = latch_q;
		rx_buf_d      = rx_buf_q;
		read_d        = 8'd0;
		sh_ext        = '0;

		if (active_q) begin
			if (!spi_enable_q) begin
				active_d      = 1'b0;
				edge_d        = '0;
				prescale_d    = '0;
				clock_level_d = 1'b0;
			end else if (pre_inc < half) begin
				prescale_d = pre_inc[PRESCALE_W-1:0];
			end else begin
				prescale_d    = '0;
				clock_level_d = !clock_level_q;
				if (clock_phase_q) begin
					if (edge_q[0]) begin
						latch_d = miso_in;
					end else if (edge_q != '0) begin
						shift_d = shift_word(shift_q, latch_q, lsb_first_q);
					end
				end else begin
					if (edge_q[0]) begin
						shift_d = shift_word(shift_q, latch_q, lsb_first_q);
					end else begin
						latch_d = miso_in;
					end
				end
				edge_d = edge_q + 1'b1;
				if (edge_d >= LAST_EDGE) begin
					if (clock_phase_q) begin
						shift_d = shift_word(shift_d, latch_d, lsb_first_q);
					end
					active_d      = 1'b0;
					edge_d        = '0;
					prescale_d    = '0;
					clock_level_d = 1'b0;
					sh_ext        = {8'd0, shift_d};
					rx_buf_d      = sh_ext[7:0];
					done_d        = 1'b1;
				end
			end
		end

		case (op_c)
			OP_WRITE: begin
				done_d      = 1'b0;
				collision_d = 1'b0;
				if (active_d) begin
					collision_d = 1'b1;
				end else if (spi_enable_q) begin
					shift_d       = wb_ext[DATA_BITS-1:0];
					edge_d        = '0;
					prescale_d    = '0;
					clock_level_d = 1'b0;
					latch_d       = 1'b0;
					active_d      = 1'b1;
				end
			end
			OP_READ: begin
				done_d      = 1'b0;
				collision_d = 1'b0;
				read_d      = rx_buf_d;
			end
			OP_STATUS: begin
				read_d[STATUS_DONE_BIT]      = done_d;
				read_d[STATUS_COLLISION_BIT] = collision_d;
			end
			default: begin
				read_d = 8'd0;
			end
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_enable_q     <= 1'b0;
			irq_enable_q     <= 1'b0;
			lsb_first_q      <= 1'b0;
			clock_polarity_q <= 1'b0;
			clock_phase_q    <= 1'b0;
			rate_select_q    <= 2'd0;
			double_speed_q   <= 1'b0;
			master_select_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPI_ENABLE:     spi_enable_q     <= cfg_data[0];
				CFG_IRQ_ENABLE:     irq_enable_q     <= cfg_data[0];
				CFG_LSB_FIRST:      lsb_first_q      <= cfg_data[0];
				CFG_CLOCK_POLARITY: clock_polarity_q <= cfg_data[0];
				CFG_CLOCK_PHASE:    clock_phase_q    <= cfg_data[0];
				CFG_RATE_SELECT:    rate_select_q    <= cfg_data[1:0];
				CFG_DOUBLE_SPEED:   double_speed_q   <= cfg_data[0];
				CFG_MASTER_SELECT:  master_select_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Commit engine state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q       <= '0;
			edge_q        <= '0;
			prescale_q    <= '0;
			active_q      <= 1'b0;
			clock_level_q <= 1'b0;
			done_q        <= 1'b0;
			collision_q   <= 1'b0;
			latch_q       <= 1'b0;
			rx_buf_q      <= 8'd0;
		end else if (accept) begin
			shift_q       <= shift_d;
			edge_q        <= edge_d;
			prescale_q    <= prescale_d;
			active_q      <= active_d;
			clock_level_q <= clock_level_d;
			done_q        <= done_d;
			collision_q   <= collision_d;
			latch_q       <= latch_d;
			rx_buf_q      <= rx_buf_d;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_d;
			sck_q        <= clock_level_d ^ clock_polarity_q;
			mosi_q       <= lsb_first_q ? shift_d[0] : shift_d[DATA_BITS-1];
			select_n_q   <= !(active_d && master_select_q);
			irq_q        <= done_d && irq_enable_q;
			busy_q       <= active_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign sck_out    = sck_q;
	assign mosi_out   = mosi_q;
	assign select_n   = select_n_q;
	assign irq        = irq_q;
	assign busy_res   = busy_q;

	// Idle engine keeps its counters and clock cleared
	`ASSERT_IMPLY(a_idle_clear, clk, arst_n, !active_q, (edge_q == '0) && (prescale_q == '0) && !clock_level_q)
	// Edge count never reaches the end while a transfer runs
	`ASSERT_IMPLY(a_edge_range, clk, arst_n, active_q, edge_q < LAST_EDGE)
	// Done flag rises only at the end of a transfer
	`ASSERT_IMPLY(a_done_source, clk, arst_n, $rose(done_q), $past(active_q))
	// An accepted beat always leaves a result in the output register
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, accept, out_valid_q)

endmodule

[tb/tb_spi_master_shift_engine.sv]
// Testbench for the SPI master shift engine: tick predictor, bus traffic and line checks.
`timescale 1ns / 1ps

module tb_spi_master_shift_engine;
	import spims_pkg::*;

	localparam int WORD_BITS = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int NUM_PHASES = 12;
	localparam logic [3:0] CFG_UNMAPPED_BASE = 4'd8;

	// One result beat: bus read data, the serial line levels, irq and busy after the tick.
	typedef struct packed {
		logic [7:0] read_value;
		logic       sck;
		logic       mosi;
		logic       sel_n;
		logic       irq;
		logic       busy;
	} tick_result_t;

	// Tick-accurate model of the engine, flags and register file.
	class spi_tick_predictor;
		bit en, irq_en, lsb, cpol, cpha, dbl, msel;
		bit [1:0] rate;
		bit [7:0] shreg, rxbuf;
		int unsigned edges, prescale;
		int unsigned half_by_rate[4] = '{2, 8, 32, 64};
		bit active, level, done, coll, latch;
		tick_result_t expected_q[$];
		int errors;

		function int unsigned half_ticks();
			return dbl ? half_by_rate[rate] >> 1 : half_by_rate[rate];
		endfunction

		function void write_reg(logic [3:0] idx, logic [7:0] data);
			case (idx)
				CFG_SPI_ENABLE:     en = data[0];
				CFG_IRQ_ENABLE:     irq_en = data[0];
				CFG_LSB_FIRST:      lsb = data[0];
				CFG_CLOCK_POLARITY: cpol = data[0];
				CFG_CLOCK_PHASE:    cpha = data[0];
				CFG_RATE_SELECT:    rate = data[1:0];
				CFG_DOUBLE_SPEED:   dbl = data[0];
				CFG_MASTER_SELECT:  msel = data[0];
				default: ;
			endcase
		endfunction

		function void shift_in(bit b);
			if (lsb)
				shreg = {b, shreg[7:1]};
			else
				shreg = {shreg[6:0], b};
		endfunction

		function void stop_engine();
			active = 0;
			edges = 0;
			prescale = 0;
			level = 0;
		endfunction

		// Advance the serial engine by one system tick.
		function void advance_clock(bit miso);
			int unsigned e;
			if (!active)
				return;
			if (!en) begin
				stop_engine();
				return;
			end
			if (prescale + 1 < half_ticks()) begin
				prescale = (prescale + 1) & 63;
				return;
			end
			prescale = 0;
			level = ~level;
			e = edges;
			if (cpha) begin
				if (e % 2)
					latch = miso;
				else if (e > 0)
					shift_in(latch);
			end else begin
				if (e % 2)
					shift_in(latch);
				else
					latch = miso;
			end
			edges = e + 1;
			// Finish the word: in phase 1 commit the last sample, then store the word and raise done.
			if (edges >= 2 * WORD_BITS) begin
				if (cpha)
					shift_in(latch);
				stop_engine();
				rxbuf = shreg;
				done = 1;
			end
		endfunction

		// Record an accepted input beat and queue the result it produces.
		function void note_tick(op_t code, logic [7:0] wb, bit miso);
			tick_result_t r;
			advance_clock(miso);
			r = '0;
			if (code == OP_WRITE || code == OP_READ) begin
				done = 0;
				coll = 0;
			end
			if (code == OP_WRITE) begin
				if (active) begin
					coll = 1;
				end else if (en) begin
					shreg = wb;
					stop_engine();
					latch = 0;
					active = 1;
				end
			end else if (code == OP_READ) begin
				r.read_value = rxbuf;
			end else if (code == OP_STATUS) begin
				r.read_value[STATUS_DONE_BIT] = done;
				r.read_value[STATUS_COLLISION_BIT] = coll;
			end
			r.sck = level ^ cpol;
			r.mosi = lsb ? shreg[0] : shreg[WORD_BITS-1];
			r.sel_n = !(active && msel);
			r.irq = done & irq_en;
			r.busy = active;
			expected_q.push_back(r);
		endfunction

		task report(string what, int got, int want);
			if (errors < 100)
				$display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		// Compare one result beat with the oldest expectation.
		task check_result(tick_result_t got);
			tick_result_t want;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected", got, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.read_value !== want.read_value)
				report("read_value", got.read_value, want.read_value);
			if (got.sck !== want.sck)
				report("sck_out", got.sck, want.sck);
			if (got.mosi !== want.mosi)
				report("mosi_out", got.mosi, want.mosi);
			if (got.sel_n !== want.sel_n)
				report("select_n", got.sel_n, want.sel_n);
			if (got.irq !== want.irq)
				report("irq", got.irq, want.irq);
			if (got.busy !== want.busy)
				report("busy_res", got.busy, want.busy);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [7:0] write_byte;
	logic miso_in;
	logic out_valid;
	logic out_stall;
	logic [7:0] read_value;
	logic sck_out;
	logic mosi_out;
	logic select_n;
	logic irq;
	logic busy_res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	spi_tick_predictor sb = new;
	int send_idle_pct;
	int recv_stall_pct;
	int ticks_sent;
	int idle_cycles;

	spi_master_shift_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.write_byte(write_byte),
		.miso_in(miso_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.sck_out(sck_out),
		.mosi_out(mosi_out),
		.select_n(select_n),
		.irq(irq),
		.busy_res(busy_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result channel at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check each accepted result beat.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(tick_result_t'{read_value, sck_out, mosi_out, select_n, irq,
				busy_res});
	end

	// Drop the run when no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("spi_master_shift_engine test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Drive one input beat, idling first at random; valid stays high afterwards.
	task automatic send_tick(op_t code, logic [7:0] wb, bit miso);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		write_byte <= wb;
		miso_in <= miso;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tick(code, wb, miso);
		ticks_sent++;
	endtask

	task automatic send_random(op_t code);
		send_tick(code, 8'($urandom), 1'($urandom_range(1)));
	endtask

	// Drop valid and wait until every queued result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; bits outside keep_mask get random filler. Valid stays high.
	task automatic cfg_write(logic [3:0] idx, logic [7:0] val, logic [7:0] keep_mask);
		logic [7:0] data;
		data = (8'($urandom) & ~keep_mask) | (val & keep_mask);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Program the whole register file for random phase k.
	task automatic set_phase(int k);
		logic [1:0] rate;
		logic dbl;
		rate = 2'($urandom_range(1));
		dbl = 1'($urandom_range(1));
		if (k == 2)
			rate = 2'd2;
		if (k == 5) begin
			rate = 2'd3;
			dbl = 1'b1;
		end
		if (k == 10) begin
			rate = 2'd3;
			dbl = 1'b0;
		end
		if (k == 11)
			rate = 2'd0;
		cfg_write(CFG_SPI_ENABLE, 8'(k != 7), 8'h01);
		cfg_write(CFG_IRQ_ENABLE, 8'($urandom_range(1)), 8'h01);
		cfg_write(CFG_LSB_FIRST, 8'(k % 2), 8'h01);
		cfg_write(CFG_CLOCK_POLARITY, 8'(((k >> 2) ^ k) % 2), 8'h01);
		cfg_write(CFG_CLOCK_PHASE, 8'((k >> 1) % 2), 8'h01);
		cfg_write(CFG_RATE_SELECT, 8'(rate), 8'h03);
		cfg_write(CFG_DOUBLE_SPEED, 8'(dbl), 8'h01);
		cfg_write(CFG_MASTER_SELECT, 8'(k % 3 != 2), 8'h01);
		if ($urandom_range(2) == 0)
			cfg_write(CFG_UNMAPPED_BASE + 4'($urandom_range(7)), 8'($urandom), 8'hFF);
		cfg_valid <= 1'b0;
	endtask

	// Run transfers with random content, plus some loose bus noise.
	task automatic run_traffic(int budget);
		int target;
		int r;
		target = ticks_sent + budget;
		while (ticks_sent < target) begin
			if ($urandom_range(99) < 80) begin
				send_random(OP_WRITE);
				while (sb.active && ticks_sent < target) begin
					r = $urandom_range(99);
					if (r < 5)
						send_random(OP_STATUS);
					else if (r < 7)
						send_random(OP_READ);
					else if (r < 9)
						send_random(OP_WRITE);
					else
						send_random(OP_TICK);
				end
				send_random(OP_STATUS);
				send_random(OP_READ);
			end else begin
				repeat ($urandom_range(6, 1))
					send_random(op_t'($urandom_range(3)));
			end
		end
	endtask

	initial begin
		int budget;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_TICK;
		write_byte = '0;
		miso_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ticks_sent = 0;
		send_idle_pct = 21;
		recv_stall_pct = 87;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: write while disabled, then a fast mode 0 transfer with a collision.
		send_tick(OP_WRITE, 8'hFF, 1'b1);
		send_tick(OP_STATUS, 8'h00, 1'b0);
		drain();
		cfg_write(CFG_SPI_ENABLE, 8'h01, 8'h01);
		cfg_write(CFG_IRQ_ENABLE, 8'h01, 8'h01);
		cfg_write(CFG_LSB_FIRST, 8'h00, 8'h01);
		cfg_write(CFG_CLOCK_POLARITY, 8'h00, 8'h01);
		cfg_write(CFG_CLOCK_PHASE, 8'h00, 8'h01);
		cfg_write(CFG_RATE_SELECT, 8'h00, 8'h03);
		cfg_write(CFG_DOUBLE_SPEED, 8'h01, 8'h01);
		cfg_write(CFG_MASTER_SELECT, 8'h01, 8'h01);
		cfg_write(CFG_UNMAPPED_BASE, 8'hFF, 8'hFF);
		cfg_valid <= 1'b0;
		send_tick(OP_WRITE, 8'hA5, 1'b0);
		send_tick(OP_WRITE, 8'h00, 1'b1);
		send_tick(OP_STATUS, 8'hFF, 1'b0);
		for (int i = 0; i < 14; i++)
			send_tick(OP_TICK, 8'h00, 1'(i ^ (i >> 2)));
		send_tick(OP_STATUS, 8'h00, 1'b1);
		send_tick(OP_READ, 8'h00, 1'b0);
		// Start another word, then disable in the middle of it.
		send_tick(OP_WRITE, 8'h3C, 1'b1);
		send_tick(OP_TICK, 8'h00, 1'b0);
		drain();
		cfg_write(CFG_SPI_ENABLE, 8'h00, 8'h01);
		cfg_valid <= 1'b0;
		send_tick(OP_TICK, 8'h00, 1'b1);
		send_tick(OP_WRITE, 8'h81, 1'b0);

		// Random phases across register settings and idle patterns.
		for (int k = 0; k < NUM_PHASES; k++) begin
			drain();
			send_idle_pct = (k < 4) ? 21 : (k < 8) ? 87 : 0;
			recv_stall_pct = (k < 4) ? 87 : (k < 8) ? 21 : 0;
			set_phase(k);
			budget = 16 * sb.half_ticks() + 30;
			if (budget < 90)
				budget = 90;
			if (k == 10)
				budget = 200;
			run_traffic(budget);
		end

		drain();
		repeat (5) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report("results never delivered", sb.expected_q.size(), 0);
		if (sb.errors == 0)
			$display("spi_master_shift_engine test passed");
		else
			$display("spi_master_shift_engine test failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/spims_pkg.sv
src/spi_master_shift_engine.sv
tb/tb_spi_master_shift_engine.sv
